// File: hw/rtl/smbg_pkg.sv
// ----------------------------------------------------------------------------
// smbg_pkg
// Types, register indexes and codes shared by the box mesh generator.
// ----------------------------------------------------------------------------
package smbg_pkg;

    localparam int MAX_GRID = 256;
    localparam int GW       = 9;
    localparam int IW       = 19;
    localparam int QW       = 17;
    localparam int DIV_STEPS = 17;
    localparam int DIV_PER_STG = 3;

    localparam logic [2:0] CFG_BOX_W  = 3'd0;
    localparam logic [2:0] CFG_BOX_H  = 3'd1;
    localparam logic [2:0] CFG_BOX_D  = 3'd2;
    localparam logic [2:0] CFG_GRID_X = 3'd3;
    localparam logic [2:0] CFG_GRID_Y = 3'd4;
    localparam logic [2:0] CFG_GRID_Z = 3'd5;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_CELL   = 1'b1;

    localparam logic [2:0] FACE_PZ = 3'd0;
    localparam logic [2:0] FACE_PX = 3'd1;
    localparam logic [2:0] FACE_NX = 3'd2;
    localparam logic [2:0] FACE_NZ = 3'd3;
    localparam logic [2:0] FACE_NY = 3'd4;
    localparam logic [2:0] FACE_PY = 3'd5;

    typedef struct packed {
        logic [15:0]   box_w;
        logic [15:0]   box_h;
        logic [15:0]   box_d;
        logic [GW-1:0] gx;
        logic [GW-1:0] gy;
        logic [GW-1:0] gz;
        logic [IW-1:0] base1;
        logic [IW-1:0] base2;
        logic [IW-1:0] base3;
        logic [IW-1:0] base4;
        logic [IW-1:0] base5;
    } t_cfg;

    typedef struct packed {
        logic          cmd;
        logic [2:0]    face;
        logic [7:0]    row;
        logic [7:0]    col;
        logic          bad;
        logic [GW-1:0] ncols;
        logic [GW-1:0] du;
        logic [GW-1:0] dv;
        logic [GW-1:0] ru;
        logic [GW-1:0] rv;
        logic [QW-1:0] qu;
        logic [QW-1:0] qv;
        logic [IW-1:0] p00;
        logic [IW-1:0] p10;
        logic [16:0]   luw;
        logic [16:0]   lud;
        logic [16:0]   lvh;
        logic [16:0]   lvd;
        logic [15:0]   px;
        logic [15:0]   py;
        logic [15:0]   pz;
    } t_stage;

endpackage

// File: hw/rtl/smbg_req_if.sv
// ----------------------------------------------------------------------------
// smbg_req_if
// Request channel: one vertex or cell request per item.
// ----------------------------------------------------------------------------
interface smbg_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [2:0] face;
    logic [7:0] grid_row;
    logic [7:0] grid_col;

    modport source (output valid, command, face, grid_row, grid_col, input ready);
    modport sink   (input valid, command, face, grid_row, grid_col, output ready);
endinterface

// File: hw/rtl/smbg_rsp_if.sv
// ----------------------------------------------------------------------------
// smbg_rsp_if
// Result channel: vertex data or one triangle per item.
// ----------------------------------------------------------------------------
interface smbg_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        last;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [2:0]  normal_code;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [18:0] corner_a;
    logic [18:0] corner_b;
    logic [18:0] corner_c;

    modport source (output valid, status, last, pos_x, pos_y, pos_z, normal_code,
                    tex_u, tex_v, corner_a, corner_b, corner_c, input ready);
    modport sink   (input valid, status, last, pos_x, pos_y, pos_z, normal_code,
                    tex_u, tex_v, corner_a, corner_b, corner_c, output ready);
endinterface

// File: hw/rtl/subdivided_box_mesh_generator_top.sv
// ----------------------------------------------------------------------------
// subdivided_box_mesh_generator_top
// Box mesh generator: vertex positions, texture coordinates and cell indices.
// ----------------------------------------------------------------------------
// A request is accepted every cycle unless the result side stalls the datapath;
// it passes through the ten datapath stages and then the result register. A
// vertex or out-of-range request yields one item; a valid cell request yields
// two items (its two triangles) and holds the result register until both are
// taken, so no new result enters before the second triangle leaves. Most of
// the datapath is the texture coordinate divider, which resolves three
// quotient bits per stage. Configuration is read by the datapath stages as a
// request passes them, so a write also affects requests already in flight;
// the face index bases follow a grid write through the product and base registers.
// ----------------------------------------------------------------------------
module subdivided_box_mesh_generator_top
    import smbg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    smbg_req_if.sink    i_req,
    smbg_rsp_if.source  o_rsp
);

    t_cfg   w_cfg;
    t_stage w_stg;
    logic   w_valid;
    logic   w_ready;

    smbg_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (w_cfg)
    );

    smbg_pipe u_pipe (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (w_cfg),
        .i_req  (i_req),
        .o_valid(w_valid),
        .o_stg  (w_stg),
        .i_ready(w_ready)
    );

    smbg_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_valid),
        .i_stg  (w_stg),
        .o_ready(w_ready),
        .o_rsp  (o_rsp)
    );

endmodule

// File: hw/rtl/smbg_cfg.sv
// ----------------------------------------------------------------------------
// smbg_cfg
// Configuration registers, clamped grid sizes and registered face index bases.
// ----------------------------------------------------------------------------
module smbg_cfg
    import smbg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [2:0]  i_idx,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    logic [15:0]   r_w, r_h, r_d;
    logic [GW-1:0] r_gx, r_gy, r_gz;
    logic [GW-1:0] n_gx, n_gy, n_gz;
    logic [IW-1:0] r_gxy, r_gzy, r_gxz;
    logic [IW-1:0] r_b1, r_b2, r_b3, r_b4, r_b5;

    function automatic logic [GW-1:0] f_clamp(logic [GW-1:0] g);
        if (g < GW'(2)) begin
            return GW'(2);
        end else if (g > GW'(MAX_GRID)) begin
            return GW'(MAX_GRID);
        end
        return g;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= 16'd256;
            r_h  <= 16'd256;
            r_d  <= 16'd256;
            r_gx <= GW'(2);
            r_gy <= GW'(2);
            r_gz <= GW'(2);
        end else if (i_we) begin
            unique case (i_idx)
                CFG_BOX_W:  r_w  <= i_data;
                CFG_BOX_H:  r_h  <= i_data;
                CFG_BOX_D:  r_d  <= i_data;
                CFG_GRID_X: r_gx <= i_data[GW-1:0];
                CFG_GRID_Y: r_gy <= i_data[GW-1:0];
                CFG_GRID_Z: r_gz <= i_data[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_gx = f_clamp(r_gx);
        n_gy = f_clamp(r_gy);
        n_gz = f_clamp(r_gz);
    end

    always_ff @(posedge i_clk) begin
        r_gxy <= IW'(n_gx) * IW'(n_gy);
        r_gzy <= IW'(n_gz) * IW'(n_gy);
        r_gxz <= IW'(n_gx) * IW'(n_gz);
        r_b1  <= r_gxy;
        r_b2  <= r_gxy + r_gzy;
        r_b3  <= r_gxy + {r_gzy[IW-2:0], 1'b0};
        r_b4  <= {r_gxy[IW-2:0], 1'b0} + {r_gzy[IW-2:0], 1'b0};
        r_b5  <= {r_gxy[IW-2:0], 1'b0} + {r_gzy[IW-2:0], 1'b0} + r_gxz;
    end

    assign o_cfg = '{box_w: r_w, box_h: r_h, box_d: r_d, gx: n_gx, gy: n_gy, gz: n_gz,
                     base1: r_b1, base2: r_b2, base3: r_b3, base4: r_b4, base5: r_b5};

endmodule

// File: hw/rtl/smbg_pipe.sv
// ----------------------------------------------------------------------------
// smbg_pipe
// Ten-stage datapath: decode, pipelined texture division, index, scale, place.
// ----------------------------------------------------------------------------
module smbg_pipe
    import smbg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    smbg_req_if.sink i_req,
    output logic   o_valid,
    output t_stage o_stg,
    input  logic   i_ready
);

    localparam int NS = 10;

    t_stage       r_s [NS];
    t_stage       n_s [NS];
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    function automatic t_stage f_div(t_stage s, int first);
        logic [GW:0] ru2, rv2;
        logic        bu, bv;
        for (int j = 0; j < DIV_PER_STG; j++) begin
            if (first + j < DIV_STEPS) begin
                bu  = (first + j == 0) ? s.col[0] : 1'b0;
                bv  = (first + j == 0) ? s.row[0] : 1'b0;
                ru2 = {s.ru, bu};
                rv2 = {s.rv, bv};
                if (ru2 >= {1'b0, s.du}) begin
                    s.ru = GW'(ru2 - {1'b0, s.du});
                    s.qu = {s.qu[QW-2:0], 1'b1};
                end else begin
                    s.ru = ru2[GW-1:0];
                    s.qu = {s.qu[QW-2:0], 1'b0};
                end
                if (rv2 >= {1'b0, s.dv}) begin
                    s.rv = GW'(rv2 - {1'b0, s.dv});
                    s.qv = {s.qv[QW-2:0], 1'b1};
                end else begin
                    s.rv = rv2[GW-1:0];
                    s.qv = {s.qv[QW-2:0], 1'b0};
                end
            end
        end
        return s;
    endfunction

    function automatic logic [15:0] f_sat(logic signed [17:0] a);
        if (a > 18'sd32767) begin
            return 16'h7FFF;
        end else if (a < -18'sd32768) begin
            return 16'h8000;
        end
        return a[15:0];
    endfunction

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_req.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_req.valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) r_s[k] <= n_s[k];
        end
    end

    logic [GW-1:0]        w_rows;
    logic [IW-1:0]        w_base;
    logic [14:0]          w_hw, w_hh, w_hd;
    logic signed [17:0]   w_x, w_y, w_z;
    logic signed [17:0]   w_lw, w_ld_u, w_lh, w_ld_v, w_hws, w_hhs, w_hds;

    always_comb begin
        // decode and capture
        n_s[0]      = '0;
        n_s[0].cmd  = i_req.command;
        n_s[0].face = i_req.face;
        n_s[0].row  = i_req.grid_row;
        n_s[0].col  = i_req.grid_col;

        n_s[1] = r_s[0];
        case (r_s[0].face) inside
            FACE_PX, FACE_NX: begin n_s[1].ncols = i_cfg.gz; w_rows = i_cfg.gy; end
            FACE_NY, FACE_PY: begin n_s[1].ncols = i_cfg.gx; w_rows = i_cfg.gz; end
            FACE_PZ, FACE_NZ: begin n_s[1].ncols = i_cfg.gx; w_rows = i_cfg.gy; end
            default:          begin n_s[1].ncols = GW'(2);   w_rows = GW'(2);   end
        endcase
        if (r_s[0].cmd == CMD_VERTEX) begin
            n_s[1].bad = ({1'b0, r_s[0].row} >= w_rows) ||
                         ({1'b0, r_s[0].col} >= n_s[1].ncols);
        end else begin
            n_s[1].bad = ({1'b0, r_s[0].row} + GW'(1) >= w_rows) ||
                         ({1'b0, r_s[0].col} + GW'(1) >= n_s[1].ncols);
        end
        if (r_s[0].face > FACE_PY) n_s[1].bad = 1'b1;
        n_s[1].du = n_s[1].ncols - GW'(1);
        n_s[1].dv = w_rows - GW'(1);
        n_s[1].ru = GW'(r_s[0].col[7:1]);
        n_s[1].rv = GW'(r_s[0].row[7:1]);

        // division, with the cell index built alongside
        n_s[2]     = f_div(r_s[1], 0);
        n_s[2].p00 = IW'(r_s[1].row) * IW'(r_s[1].ncols) + IW'(r_s[1].col);

        case (r_s[2].face)
            FACE_PX: w_base = i_cfg.base1;
            FACE_NX: w_base = i_cfg.base2;
            FACE_NZ: w_base = i_cfg.base3;
            FACE_NY: w_base = i_cfg.base4;
            FACE_PY: w_base = i_cfg.base5;
            default: w_base = '0;
        endcase
        n_s[3]     = f_div(r_s[2], DIV_PER_STG);
        n_s[3].p00 = r_s[2].p00 + w_base;

        n_s[4]     = f_div(r_s[3], 2 * DIV_PER_STG);
        n_s[4].p10 = r_s[3].p00 + IW'(r_s[3].ncols);

        n_s[5] = f_div(r_s[4], 3 * DIV_PER_STG);
        n_s[6] = f_div(r_s[5], 4 * DIV_PER_STG);
        n_s[7] = f_div(r_s[6], 5 * DIV_PER_STG);

        // scale by box size
        n_s[8]     = r_s[7];
        n_s[8].luw = 17'((33'(r_s[7].qu) * 33'(i_cfg.box_w)) >> 16);
        n_s[8].lud = 17'((33'(r_s[7].qu) * 33'(i_cfg.box_d)) >> 16);
        n_s[8].lvh = 17'((33'(r_s[7].qv) * 33'(i_cfg.box_h)) >> 16);
        n_s[8].lvd = 17'((33'(r_s[7].qv) * 33'(i_cfg.box_d)) >> 16);

        // place on the face and saturate
        w_hw   = i_cfg.box_w[15:1];
        w_hh   = i_cfg.box_h[15:1];
        w_hd   = i_cfg.box_d[15:1];
        w_hws  = $signed({3'b0, w_hw});
        w_hhs  = $signed({3'b0, w_hh});
        w_hds  = $signed({3'b0, w_hd});
        w_lw   = $signed({1'b0, r_s[8].luw});
        w_ld_u = $signed({1'b0, r_s[8].lud});
        w_lh   = $signed({1'b0, r_s[8].lvh});
        w_ld_v = $signed({1'b0, r_s[8].lvd});
        case (r_s[8].face)
            FACE_PZ: begin w_x = w_lw - w_hws;  w_y = w_lh - w_hhs; w_z = w_hds; end
            FACE_PX: begin w_x = w_hws;  w_y = w_lh - w_hhs; w_z = w_hds - w_ld_u; end
            FACE_NX: begin w_x = -w_hws; w_y = w_lh - w_hhs; w_z = w_ld_u - w_hds; end
            FACE_NZ: begin w_x = w_hws - w_lw;  w_y = w_lh - w_hhs; w_z = -w_hds; end
            FACE_NY: begin w_x = w_lw - w_hws;  w_y = -w_hhs; w_z = w_ld_v - w_hds; end
            default: begin w_x = w_lw - w_hws;  w_y = w_hhs;  w_z = w_hds - w_ld_v; end
        endcase
        n_s[9]    = r_s[8];
        n_s[9].px = f_sat(w_x);
        n_s[9].py = f_sat(w_y);
        n_s[9].pz = f_sat(w_z);
    end

    assign o_valid = r_v[NS-1];
    assign o_stg   = r_s[NS-1];

endmodule

// File: hw/rtl/smbg_out.sv
// ----------------------------------------------------------------------------
// smbg_out
// Result register: emits one item per vertex or out-of-range request and two items per valid cell.
// ----------------------------------------------------------------------------
module smbg_out
    import smbg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stg,
    output logic   o_ready,
    smbg_rsp_if.source o_rsp
);

    t_stage r_rec;
    logic   r_vld;
    logic   r_ph;
    logic   w_final;
    logic   w_take;

    assign w_final = r_rec.bad || (r_rec.cmd == CMD_VERTEX) || r_ph;
    assign w_take  = !r_vld || (o_rsp.ready && w_final);
    assign o_ready = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_ph  <= 1'b0;
        end else if (w_take) begin
            r_vld <= i_valid;
            r_ph  <= 1'b0;
        end else if (o_rsp.ready) begin
            r_ph <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_rec <= i_stg;
    end

    always_comb begin
        o_rsp.valid       = r_vld;
        o_rsp.status      = 1'b0;
        o_rsp.last        = 1'b1;
        o_rsp.pos_x       = '0;
        o_rsp.pos_y       = '0;
        o_rsp.pos_z       = '0;
        o_rsp.normal_code = r_rec.face;
        o_rsp.tex_u       = '0;
        o_rsp.tex_v       = '0;
        o_rsp.corner_a    = '0;
        o_rsp.corner_b    = '0;
        o_rsp.corner_c    = '0;
        if (r_rec.bad) begin
            o_rsp.status      = 1'b1;
            o_rsp.normal_code = '0;
        end else if (r_rec.cmd == CMD_VERTEX) begin
            o_rsp.pos_x = r_rec.px;
            o_rsp.pos_y = r_rec.py;
            o_rsp.pos_z = r_rec.pz;
            o_rsp.tex_u = r_rec.qu;
            o_rsp.tex_v = r_rec.qv;
        end else if (!r_ph) begin
            o_rsp.last     = 1'b0;
            o_rsp.corner_a = r_rec.p00;
            o_rsp.corner_b = r_rec.p00 + IW'(1);
            o_rsp.corner_c = r_rec.p10;
        end else begin
            o_rsp.corner_a = r_rec.p00 + IW'(1);
            o_rsp.corner_b = r_rec.p10 + IW'(1);
            o_rsp.corner_c = r_rec.p10;
        end
    end

endmodule

// File: hw/rtl/smbg_chk.sv
// ----------------------------------------------------------------------------
// smbg_chk
// Port-level checks on the result stream of the box mesh generator.
// ----------------------------------------------------------------------------
module smbg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_status,
    input logic        i_last,
    input logic [2:0]  i_normal,
    input logic [18:0] i_ca,
    input logic [18:0] i_cb,
    input logic [18:0] i_cc
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_ca) && $stable(i_last))
        else $error("result dropped or changed while stalled");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status |-> i_last && i_normal == 3'd0 && i_ca == 19'd0)
        else $error("error result not final or not cleared");

    a_tri1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> !i_status && i_cb == i_ca + 19'd1)
        else $error("first triangle corners inconsistent");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=>
            i_valid && i_last && i_cc == $past(i_cc) && i_ca == $past(i_cb))
        else $error("second triangle missing or not sharing edge");

endmodule

bind subdivided_box_mesh_generator_top smbg_chk u_smbg_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_status(o_rsp.status),
    .i_last  (o_rsp.last),
    .i_normal(o_rsp.normal_code),
    .i_ca    (o_rsp.corner_a),
    .i_cb    (o_rsp.corner_b),
    .i_cc    (o_rsp.corner_c)
);

// File: dv/tb_subdivided_box_mesh_generator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subdivided_box_mesh_generator_top
// Drives vertex and cell requests into the box mesh generator under several
// box and grid settings and idle patterns, and checks every result item
// against a predictor of positions, texture coordinates and cell indices.
// ----------------------------------------------------------------------------
module tb_subdivided_box_mesh_generator_top;
    import smbg_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;

    typedef struct packed {
        logic        status;
        logic        last;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [2:0]  normal_code;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [18:0] corner_a;
        logic [18:0] corner_b;
        logic [18:0] corner_c;
    } t_mesh_item;

    typedef struct {
        logic       command;
        logic [2:0] face;
        logic [7:0] grid_row;
        logic [7:0] grid_col;
        logic       typed;
        t_mesh_item first;
    } t_req_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    smbg_req_if req_ch ();
    smbg_rsp_if rsp_ch ();

    subdivided_box_mesh_generator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    logic [15:0] box_w_q, box_h_q, box_d_q;
    logic [8:0]  gx_q, gy_q, gz_q;
    t_mesh_item  mesh_expected[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("subdivided_box_mesh_generator_top: mismatch");
            $finish;
        end
    end

    function automatic int clamp_grid(input logic [8:0] g);
        if (g < 2) return 2;
        if (g > MAX_GRID) return MAX_GRID;
        return g;
    endfunction

    function automatic longint scale_q(input longint t, input logic [15:0] sz);
        return (t * longint'(sz)) >>> 16;
    endfunction

    function automatic logic [15:0] clip16(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic enqueue_item(input t_mesh_item it);
        mesh_expected = {mesh_expected, it};
    endtask

    task automatic predict_mesh(input logic cmd, input logic [2:0] face,
                                input logic [7:0] row, input logic [7:0] col);
        longint gx, gy, gz, ncol, nrow, base, u, v, hw, hh, hd, x, y, z, p00, p10;
        logic bad;
        t_mesh_item r;
        gx = clamp_grid(gx_q);
        gy = clamp_grid(gy_q);
        gz = clamp_grid(gz_q);
        ncol = 2; nrow = 2; base = 0;
        case (face)
            FACE_PZ: begin ncol = gx; nrow = gy; base = 0; end
            FACE_PX: begin ncol = gz; nrow = gy; base = gx*gy; end
            FACE_NX: begin ncol = gz; nrow = gy; base = gx*gy + gz*gy; end
            FACE_NZ: begin ncol = gx; nrow = gy; base = gx*gy + 2*gz*gy; end
            FACE_NY: begin ncol = gx; nrow = gz; base = 2*gx*gy + 2*gz*gy; end
            FACE_PY: begin ncol = gx; nrow = gz; base = 2*gx*gy + 2*gz*gy + gx*gz; end
            default: ;
        endcase
        if (cmd == CMD_VERTEX) bad = face > FACE_PY || row >= nrow || col >= ncol;
        else bad = face > FACE_PY || row + 1 >= nrow || col + 1 >= ncol;
        r = '0;
        r.last = 1'b1;
        if (bad) begin
            r.status = 1'b1;
            enqueue_item(r);
        end else if (cmd == CMD_VERTEX) begin
            u = (longint'(col) << 16) / (ncol - 1);
            v = (longint'(row) << 16) / (nrow - 1);
            hw = box_w_q >> 1; hh = box_h_q >> 1; hd = box_d_q >> 1;
            case (face)
                FACE_PZ: begin x = scale_q(u, box_w_q) - hw;
                    y = scale_q(v, box_h_q) - hh; z = hd; end
                FACE_PX: begin x = hw; y = scale_q(v, box_h_q) - hh;
                    z = hd - scale_q(u, box_d_q); end
                FACE_NX: begin x = -hw; y = scale_q(v, box_h_q) - hh;
                    z = scale_q(u, box_d_q) - hd; end
                FACE_NZ: begin x = hw - scale_q(u, box_w_q);
                    y = scale_q(v, box_h_q) - hh; z = -hd; end
                FACE_NY: begin x = scale_q(u, box_w_q) - hw; y = -hh;
                    z = scale_q(v, box_d_q) - hd; end
                default: begin x = scale_q(u, box_w_q) - hw; y = hh;
                    z = hd - scale_q(v, box_d_q); end
            endcase
            r.pos_x = clip16(x);
            r.pos_y = clip16(y);
            r.pos_z = clip16(z);
            r.normal_code = face;
            r.tex_u = u[16:0];
            r.tex_v = v[16:0];
            enqueue_item(r);
        end else begin
            p00 = base + row*ncol + col;
            p10 = base + (row + 1)*ncol + col;
            r.normal_code = face;
            r.last = 1'b0;
            r.corner_a = p00[18:0];
            r.corner_b = p00[18:0] + 19'd1;
            r.corner_c = p10[18:0];
            enqueue_item(r);
            r.last = 1'b1;
            r.corner_a = p00[18:0] + 19'd1;
            r.corner_b = p10[18:0] + 19'd1;
            enqueue_item(r);
        end
    endtask

    task automatic report_mismatch(input string what, input t_mesh_item got,
                                   input t_mesh_item want);
        $display("mesh item %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_mesh_item got, want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.status, rsp_ch.last, rsp_ch.pos_x, rsp_ch.pos_y,
                    rsp_ch.pos_z, rsp_ch.normal_code, rsp_ch.tex_u, rsp_ch.tex_v,
                    rsp_ch.corner_a, rsp_ch.corner_b, rsp_ch.corner_c};
            if (mesh_expected.size() == 0) begin
                report_mismatch("unexpected", got, '0);
            end else begin
                want = mesh_expected.pop_front();
                if (got.status != want.status) report_mismatch("status", got, want);
                if (got.last != want.last) report_mismatch("last", got, want);
                if (got.pos_x != want.pos_x) report_mismatch("pos_x", got, want);
                if (got.pos_y != want.pos_y) report_mismatch("pos_y", got, want);
                if (got.pos_z != want.pos_z) report_mismatch("pos_z", got, want);
                if (got.normal_code != want.normal_code)
                    report_mismatch("normal_code", got, want);
                if (got.tex_u != want.tex_u) report_mismatch("tex_u", got, want);
                if (got.tex_v != want.tex_v) report_mismatch("tex_v", got, want);
                if (got.corner_a != want.corner_a) report_mismatch("corner_a", got, want);
                if (got.corner_b != want.corner_b) report_mismatch("corner_b", got, want);
                if (got.corner_c != want.corner_c) report_mismatch("corner_c", got, want);
            end
        end
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BOX_W:  box_w_q = val;
            CFG_BOX_H:  box_h_q = val;
            CFG_BOX_D:  box_d_q = val;
            CFG_GRID_X: gx_q = val[8:0];
            CFG_GRID_Y: gy_q = val[8:0];
            CFG_GRID_Z: gz_q = val[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_request(input logic cmd, input logic [2:0] face,
                                input logic [7:0] row, input logic [7:0] col);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.face <= face;
        req_ch.grid_row <= row;
        req_ch.grid_col <= col;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end
        predict_mesh(cmd, face, row, col);
    endtask

    task automatic drain_and_idle();
        req_ch.valid <= 1'b0;
        while (mesh_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_requests(input int count, input int maxrow, input int maxcol);
        logic [2:0] f;
        int n;
        for (n = 0; n < count; n++) begin
            f = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
            if ($urandom_range(9) == 0)
                send_request(1'($urandom), f, 8'($urandom), 8'($urandom));
            else
                send_request(1'($urandom), f, 8'($urandom_range(maxrow)),
                             8'($urandom_range(maxcol)));
        end
    endtask

    t_req_row directed_rows[] = '{
        '{CMD_VERTEX, FACE_PZ, 8'd0, 8'd0, 1'b1,
          '{1'b0, 1'b1, 16'hff80, 16'hff80, 16'h0080, FACE_PZ, 17'd0, 17'd0,
            19'd0, 19'd0, 19'd0}},
        '{CMD_VERTEX, FACE_PZ, 8'd1, 8'd1, 1'b1,
          '{1'b0, 1'b1, 16'h0080, 16'h0080, 16'h0080, FACE_PZ, 17'h10000, 17'h10000,
            19'd0, 19'd0, 19'd0}},
        '{CMD_VERTEX, FACE_PZ, 8'd2, 8'd0, 1'b1,
          '{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 3'd0, 17'd0, 17'd0, 19'd0, 19'd0, 19'd0}},
        '{CMD_VERTEX, 3'd6, 8'd0, 8'd0, 1'b1,
          '{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 3'd0, 17'd0, 17'd0, 19'd0, 19'd0, 19'd0}},
        '{CMD_CELL, 3'd7, 8'd0, 8'd0, 1'b1,
          '{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 3'd0, 17'd0, 17'd0, 19'd0, 19'd0, 19'd0}},
        '{CMD_CELL, FACE_PZ, 8'd1, 8'd0, 1'b1,
          '{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 3'd0, 17'd0, 17'd0, 19'd0, 19'd0, 19'd0}},
        '{CMD_CELL, FACE_PZ, 8'd255, 8'd255, 1'b1,
          '{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 3'd0, 17'd0, 17'd0, 19'd0, 19'd0, 19'd0}},
        '{CMD_CELL, FACE_PZ, 8'd0, 8'd0, 1'b0, '0},
        '{CMD_CELL, FACE_PX, 8'd0, 8'd0, 1'b0, '0},
        '{CMD_CELL, FACE_NX, 8'd0, 8'd0, 1'b0, '0},
        '{CMD_CELL, FACE_NZ, 8'd0, 8'd0, 1'b0, '0},
        '{CMD_CELL, FACE_NY, 8'd0, 8'd0, 1'b0, '0},
        '{CMD_CELL, FACE_PY, 8'd0, 8'd0, 1'b0, '0},
        '{CMD_VERTEX, FACE_PX, 8'd1, 8'd0, 1'b0, '0},
        '{CMD_VERTEX, FACE_NX, 8'd0, 8'd1, 1'b0, '0},
        '{CMD_VERTEX, FACE_NZ, 8'd1, 8'd1, 1'b0, '0},
        '{CMD_VERTEX, FACE_NY, 8'd0, 8'd1, 1'b0, '0},
        '{CMD_VERTEX, FACE_PY, 8'd1, 8'd0, 1'b0, '0},
        '{CMD_VERTEX, FACE_PY, 8'd255, 8'd255, 1'b0, '0}
    };

    initial begin
        t_mesh_item typed_want;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BOX_W;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_VERTEX;
        req_ch.face = FACE_PZ;
        req_ch.grid_row = '0;
        req_ch.grid_col = '0;
        box_w_q = 16'd256; box_h_q = 16'd256; box_d_q = 16'd256;
        gx_q = 9'd2; gy_q = 9'd2; gz_q = 9'd2;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: typed results are checked against the predictor's output up front
        foreach (directed_rows[k]) begin
            if (directed_rows[k].typed) begin
                predict_mesh(directed_rows[k].command, directed_rows[k].face,
                             directed_rows[k].grid_row, directed_rows[k].grid_col);
                // drop it again so send_request predicts once
                typed_want = mesh_expected.pop_back();
                if (typed_want != directed_rows[k].first) begin
                    $display("table row %0d disagrees with predictor", k);
                    mismatch_count++;
                end
            end
            send_request(directed_rows[k].command, directed_rows[k].face,
                         directed_rows[k].grid_row, directed_rows[k].grid_col);
        end
        drain_and_idle();

        write_reg(CFG_BOX_W, 16'hffff);
        write_reg(CFG_BOX_H, 16'd0);
        write_reg(CFG_BOX_D, 16'd301);
        write_reg(CFG_GRID_X, 16'd256);
        write_reg(CFG_GRID_Y, 16'd1);
        write_reg(CFG_GRID_Z, 16'h1ff);
        write_reg(CFG_UNUSED, 16'h1234);
        random_requests(250, 255, 255);
        drain_and_idle();

        send_idle_pct = 57;
        write_reg(CFG_BOX_W, 16'd517);
        write_reg(CFG_BOX_H, 16'hffff);
        write_reg(CFG_BOX_D, 16'd0);
        write_reg(CFG_GRID_X, 16'd7);
        write_reg(CFG_GRID_Y, 16'd13);
        write_reg(CFG_GRID_Z, 16'd3);
        random_requests(450, 14, 14);
        drain_and_idle();

        send_idle_pct = 0;
        recv_stall_pct = 57;
        write_reg(CFG_BOX_W, 16'd1000);
        write_reg(CFG_BOX_H, 16'd77);
        write_reg(CFG_BOX_D, 16'hffff);
        write_reg(CFG_GRID_X, 16'd0);
        write_reg(CFG_GRID_Y, 16'd256);
        write_reg(CFG_GRID_Z, 16'd255);
        random_requests(450, 255, 3);
        drain_and_idle();

        send_idle_pct = 29;
        recv_stall_pct = 29;
        write_reg(CFG_BOX_W, 16'd3);
        write_reg(CFG_BOX_H, 16'd12345);
        write_reg(CFG_BOX_D, 16'd40000);
        write_reg(CFG_GRID_X, 16'd5);
        write_reg(CFG_GRID_Y, 16'd4);
        write_reg(CFG_GRID_Z, 16'd9);
        random_requests(450, 10, 10);
        drain_and_idle();

        if (mismatch_count == 0) begin
            $display("subdivided_box_mesh_generator_top: match");
        end else begin
            $display("subdivided_box_mesh_generator_top: mismatch");
        end
        $finish;
    end
endmodule
